### design/bgs_pkg.sv
// Shared types and constants of the bilinear grid sampler.
package bgs_pkg;

   typedef enum logic [0:0] {
      OP_WRITE  = 1'b0,
      OP_SAMPLE = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      REG_ORIGIN_X    = 3'd0,
      REG_ORIGIN_Y    = 3'd1,
      REG_INV_CELL    = 3'd2,
      REG_GRID_WIDTH  = 3'd3,
      REG_GRID_HEIGHT = 3'd4
   } reg_index_type;

   localparam logic [31:0] ORIGIN_RESET   = 32'd0;
   localparam logic [31:0] INV_CELL_RESET = 32'd65536;
   localparam logic [6:0]  SIZE_RESET     = 7'd64;

   // Per-axis settings handed to a locate unit.
   typedef struct packed {
      logic [31:0] origin;
      logic [31:0] inv_cell_length;
      logic [6:0]  size;
   } axis_cfg_type;

endpackage

### design/bgs_axis.sv
// One axis: scaled offset, floor to cell index, fraction and clamped neighbor indices.
module bgs_axis #(
   parameter int MAX_N     = 64,
   parameter int FRAC_BITS = 16
) (
   input  logic                         clock,
   input  logic signed [31:0]           pos,
   input  bgs_pkg::axis_cfg_type        cfg,
   output logic [$clog2(MAX_N)-1:0]     idx0,
   output logic [$clog2(MAX_N)-1:0]     idx1,
   output logic [FRAC_BITS-1:0]         frac
);

   localparam int IXW = $clog2(MAX_N);
   localparam int PW  = 66;
   localparam int IW  = PW - 2 * FRAC_BITS;

   logic signed [32:0]    d_ff, d_in;
   logic [63:0]           lo_ff, lo_in;
   logic                  neg_ff;
   logic signed [PW-1:0]  prod;
   logic signed [IW-1:0]  cell_ff;
   logic [FRAC_BITS-1:0]  frac_ff, frac_out_ff;
   logic [IXW-1:0]        last_idx;
   logic signed [IW-1:0]  last_s;
   logic                  below, above, at_or_above;
   logic [IXW-1:0]        idx0_ff, idx0_in, idx1_ff, idx1_in;

   assign d_in  = $signed({pos[31], pos}) - $signed({cfg.origin[31], cfg.origin});
   assign lo_in = d_ff[31:0] * cfg.inv_cell_length;

   // d = low32 - sign*2^32, so the sign bit takes inv*2^32 off the product
   assign prod = $signed({2'b00, lo_ff})
               - (neg_ff ? $signed({2'b00, cfg.inv_cell_length, 32'd0}) : {PW{1'b0}});

   always_comb begin
      if (cfg.size == 7'd0) begin
         last_idx = '0;
      end else if (int'(cfg.size) > MAX_N) begin
         last_idx = IXW'(MAX_N - 1);
      end else begin
         last_idx = IXW'(cfg.size - 7'd1);
      end
   end

   assign last_s      = $signed({{(IW - IXW){1'b0}}, last_idx});
   assign below       = cell_ff[IW-1];
   assign above       = cell_ff > last_s;
   assign at_or_above = cell_ff >= last_s;

   always_comb begin
      if (below) begin
         idx0_in = '0;
         idx1_in = '0;
      end else begin
         idx0_in = above ? last_idx : cell_ff[IXW-1:0];
         idx1_in = at_or_above ? last_idx : cell_ff[IXW-1:0] + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      d_ff        <= d_in;
      lo_ff       <= lo_in;
      neg_ff      <= d_ff[32];
      cell_ff     <= prod[PW-1:2*FRAC_BITS];
      frac_ff     <= prod[2*FRAC_BITS-1:FRAC_BITS];
      idx0_ff     <= idx0_in;
      idx1_ff     <= idx1_in;
      frac_out_ff <= frac_ff;
   end

   assign idx0 = idx0_ff;
   assign idx1 = idx1_ff;
   assign frac = frac_out_ff;

endmodule

### design/bgs_grid_mem.sv
// Grid sample store: two copies, each with one write port and two registered reads.
module bgs_grid_mem #(
   parameter int MAX_COLS = 64,
   parameter int MAX_ROWS = 64
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(MAX_COLS)-1:0]   wr_col,
   input  logic [$clog2(MAX_ROWS)-1:0]   wr_row,
   input  logic [31:0]                   wr_data,
   input  logic [$clog2(MAX_COLS)-1:0]   rd_col0,
   input  logic [$clog2(MAX_COLS)-1:0]   rd_col1,
   input  logic [$clog2(MAX_ROWS)-1:0]   rd_row0,
   input  logic [$clog2(MAX_ROWS)-1:0]   rd_row1,
   output logic [31:0]                   q00,
   output logic [31:0]                   q01,
   output logic [31:0]                   q10,
   output logic [31:0]                   q11
);

   localparam int CW    = $clog2(MAX_COLS);
   localparam int RW    = $clog2(MAX_ROWS);
   localparam int DEPTH = MAX_COLS * MAX_ROWS;
   localparam int AW    = $clog2(DEPTH);

   logic [31:0] bank_a_ff [DEPTH];
   logic [31:0] bank_b_ff [DEPTH];
   logic [31:0] q00_ff, q01_ff, q10_ff, q11_ff;

   function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] row,
                                             input logic [CW-1:0] col);
      addr_of = AW'(row) * AW'(MAX_COLS) + AW'(col);
   endfunction

   // copy A serves the left column, copy B the right column
   always_ff @(posedge clock) begin
      if (wr_en) begin
         bank_a_ff[addr_of(wr_row, wr_col)] <= wr_data;
      end
      q00_ff <= bank_a_ff[addr_of(rd_row0, rd_col0)];
      q01_ff <= bank_a_ff[addr_of(rd_row1, rd_col0)];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bank_b_ff[addr_of(wr_row, wr_col)] <= wr_data;
      end
      q10_ff <= bank_b_ff[addr_of(rd_row0, rd_col1)];
      q11_ff <= bank_b_ff[addr_of(rd_row1, rd_col1)];
   end

   assign q00 = q00_ff;
   assign q01 = q01_ff;
   assign q10 = q10_ff;
   assign q11 = q11_ff;

endmodule

### design/bgs_lerp.sv
// Two-stage linear blend a*(1-f) + b*f, floored to the sample fraction width.
module bgs_lerp #(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic signed [31:0]    a,
   input  logic signed [31:0]    b,
   input  logic [FRAC_BITS-1:0]  f,
   output logic signed [31:0]    q
);

   localparam int PW = 34 + FRAC_BITS;
   localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

   logic [FRAC_BITS:0]          wf;
   logic signed [FRAC_BITS+1:0] wa, wb;
   logic signed [PW-1:0]        pa_ff, pa_in, pb_ff, pb_in;
   logic signed [PW:0]          sum;
   logic signed [31:0]          q_ff;

   assign wf    = ONE - {1'b0, f};
   assign wa    = $signed({1'b0, wf});
   assign wb    = $signed({2'b00, f});
   assign pa_in = a * wa;
   assign pb_in = b * wb;

   // a convex blend stays between its corners, so the floored sum fits 32 bits
   assign sum = $signed({pa_ff[PW-1], pa_ff}) + $signed({pb_ff[PW-1], pb_ff});

   always_ff @(posedge clock) begin
      pa_ff <= pa_in;
      pb_ff <= pb_in;
      q_ff  <= sum[FRAC_BITS+31:FRAC_BITS];
   end

   assign q = q_ff;

endmodule

### design/bilinear_grid_sampler_clamped.sv
// Top level of the clamp-to-edge bilinear grid sampler.
//
// Usage:
//   Command channel: a word is taken at a rising edge with start high and busy low.
//   busy never rises, so one word can be issued every cycle. A write word
//   (opcode write) stores one grid entry and gives no result; a sample word
//   gives exactly one result. Writes are seen by every sample issued after them.
//   Result channel: rsp_sampled_value is valid while rsp_strobe is high, for
//   one cycle. Results come out in issue order; the receiver cannot stall them.
//   Throughput: one word per cycle, set by the fully registered pipeline:
//   offset, 32x32 multiply, index/fraction, clamp, grid read (two store copies,
//   four reads per cycle), then two multiply-and-sum stages per blend.
//   Configuration: APB-style port, registers at byte addresses 0,4,8,12,16
//   (origin_x, origin_y, inv_cell_length, grid_width, grid_height); write only
//   while no word is in flight. pready is always high.
//   Reset: synchronous; clears the pipeline valid bits and restores register
//   defaults. Grid contents stay undefined until written; no clearing pass.
module bilinear_grid_sampler_clamped #(
   parameter int MAX_COLS  = 64,
   parameter int MAX_ROWS  = 64,
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   // command channel
   input  logic               start,
   output logic               busy,
   input  logic               req_opcode,
   input  logic [5:0]         req_write_col,
   input  logic [5:0]         req_write_row,
   input  logic signed [31:0] req_write_value,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   // result channel
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_sampled_value,
   // configuration port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam int CW         = $clog2(MAX_COLS);
   localparam int RW         = $clog2(MAX_ROWS);
   localparam int SMP_STAGES = 9;   // accept to result strobe
   localparam int WR_STAGES  = 4;   // accept to store write, aligned with the grid read

   // ---------------- configuration registers ----------------
   logic [31:0] csr_origin_x_ff, csr_origin_y_ff, csr_inv_ff;
   logic [6:0]  csr_width_ff, csr_height_ff;
   logic        csr_write;
   bgs_pkg::reg_index_type csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = bgs_pkg::reg_index_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_origin_x_ff <= bgs_pkg::ORIGIN_RESET;
         csr_origin_y_ff <= bgs_pkg::ORIGIN_RESET;
         csr_inv_ff      <= bgs_pkg::INV_CELL_RESET;
         csr_width_ff    <= bgs_pkg::SIZE_RESET;
         csr_height_ff   <= bgs_pkg::SIZE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            bgs_pkg::REG_ORIGIN_X:    csr_origin_x_ff <= pwdata;
            bgs_pkg::REG_ORIGIN_Y:    csr_origin_y_ff <= pwdata;
            bgs_pkg::REG_INV_CELL:    csr_inv_ff      <= pwdata;
            bgs_pkg::REG_GRID_WIDTH:  csr_width_ff    <= pwdata[6:0];
            bgs_pkg::REG_GRID_HEIGHT: csr_height_ff   <= pwdata[6:0];
            default: ;   // drop writes past the register list
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         bgs_pkg::REG_ORIGIN_X:    prdata = csr_origin_x_ff;
         bgs_pkg::REG_ORIGIN_Y:    prdata = csr_origin_y_ff;
         bgs_pkg::REG_INV_CELL:    prdata = csr_inv_ff;
         bgs_pkg::REG_GRID_WIDTH:  prdata = {25'd0, csr_width_ff};
         bgs_pkg::REG_GRID_HEIGHT: prdata = {25'd0, csr_height_ff};
         default:                  prdata = 32'd0;
      endcase
   end

   // ---------------- word intake ----------------
   logic          accept, take_sample, take_write;
   logic [CW+5:0] col_ext;
   logic [RW+5:0] row_ext;

   assign busy        = 1'b0;
   assign accept      = start && !busy;
   assign take_sample = accept && (req_opcode == bgs_pkg::OP_SAMPLE);
   // writes outside the store are dropped here
   assign take_write  = accept && (req_opcode == bgs_pkg::OP_WRITE)
                        && (int'(req_write_col) < MAX_COLS)
                        && (int'(req_write_row) < MAX_ROWS);
   assign col_ext     = {{CW{1'b0}}, req_write_col};
   assign row_ext     = {{RW{1'b0}}, req_write_row};

   // valid bits ride alongside the data; the pipeline never stalls
   logic [SMP_STAGES-1:0] smp_vld_ff;
   logic [WR_STAGES-1:0]  wr_vld_ff;
   logic [CW-1:0]         wr_col_ff  [WR_STAGES];
   logic [RW-1:0]         wr_row_ff  [WR_STAGES];
   logic [31:0]           wr_data_ff [WR_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         smp_vld_ff <= '0;
         wr_vld_ff  <= '0;
      end else begin
         smp_vld_ff <= {smp_vld_ff[SMP_STAGES-2:0], take_sample};
         wr_vld_ff  <= {wr_vld_ff[WR_STAGES-2:0], take_write};
      end
   end

   always_ff @(posedge clock) begin
      wr_col_ff[0]  <= col_ext[CW-1:0];
      wr_row_ff[0]  <= row_ext[RW-1:0];
      wr_data_ff[0] <= req_write_value;
      for (int k = 1; k < WR_STAGES; k++) begin
         wr_col_ff[k]  <= wr_col_ff[k-1];
         wr_row_ff[k]  <= wr_row_ff[k-1];
         wr_data_ff[k] <= wr_data_ff[k-1];
      end
   end

   // ---------------- locate both axes ----------------
   bgs_pkg::axis_cfg_type cfg_x, cfg_y;
   logic [CW-1:0]         col0, col1;
   logic [RW-1:0]         row0, row1;
   logic [FRAC_BITS-1:0]  frac_x, frac_y;

   assign cfg_x = '{origin: csr_origin_x_ff, inv_cell_length: csr_inv_ff, size: csr_width_ff};
   assign cfg_y = '{origin: csr_origin_y_ff, inv_cell_length: csr_inv_ff, size: csr_height_ff};

   bgs_axis #(.MAX_N(MAX_COLS), .FRAC_BITS(FRAC_BITS)) u_axis_x (
      .clock (clock),
      .pos   (req_pos_x),
      .cfg   (cfg_x),
      .idx0  (col0),
      .idx1  (col1),
      .frac  (frac_x)
   );

   bgs_axis #(.MAX_N(MAX_ROWS), .FRAC_BITS(FRAC_BITS)) u_axis_y (
      .clock (clock),
      .pos   (req_pos_y),
      .cfg   (cfg_y),
      .idx0  (row0),
      .idx1  (row1),
      .frac  (frac_y)
   );

   // ---------------- grid read ----------------
   // The store write sits at the same stage as the sample read, so each sample
   // sees exactly the writes issued before it.
   logic [31:0] q00, q01, q10, q11;

   bgs_grid_mem #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_grid (
      .clock   (clock),
      .wr_en   (wr_vld_ff[WR_STAGES-1]),
      .wr_col  (wr_col_ff[WR_STAGES-1]),
      .wr_row  (wr_row_ff[WR_STAGES-1]),
      .wr_data (wr_data_ff[WR_STAGES-1]),
      .rd_col0 (col0),
      .rd_col1 (col1),
      .rd_row0 (row0),
      .rd_row1 (row1),
      .q00     (q00),
      .q01     (q01),
      .q10     (q10),
      .q11     (q11)
   );

   // ---------------- blends ----------------
   // Hold the fractions until their blend stage: y meets the grid data,
   // x meets the two column results.
   logic [FRAC_BITS-1:0] fy_ff;
   logic [FRAC_BITS-1:0] fx_ff [3];
   logic signed [31:0]   y0, y1;

   always_ff @(posedge clock) begin
      fy_ff    <= frac_y;
      fx_ff[0] <= frac_x;
      fx_ff[1] <= fx_ff[0];
      fx_ff[2] <= fx_ff[1];
   end

   bgs_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_y0 (
      .clock (clock),
      .a     ($signed(q00)),
      .b     ($signed(q01)),
      .f     (fy_ff),
      .q     (y0)
   );

   bgs_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_y1 (
      .clock (clock),
      .a     ($signed(q10)),
      .b     ($signed(q11)),
      .f     (fy_ff),
      .q     (y1)
   );

   // The blend of in-range corners never leaves the 32-bit range, so the
   // saturation of the result is already met here.
   bgs_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_x (
      .clock (clock),
      .a     (y0),
      .b     (y1),
      .f     (fx_ff[2]),
      .q     (rsp_sampled_value)
   );

   assign rsp_strobe = smp_vld_ff[SMP_STAGES-1];

`ifndef SYNTHESIS
   a_sample_gives_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_opcode == bgs_pkg::OP_SAMPLE) |-> ##SMP_STAGES rsp_strobe)
      else $error("sample word without result");

   a_result_from_sample: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy && req_opcode == bgs_pkg::OP_SAMPLE, SMP_STAGES))
      else $error("result without matching sample word");

   a_write_no_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_opcode == bgs_pkg::OP_WRITE) |-> ##SMP_STAGES !rsp_strobe)
      else $error("write word produced a result");
`endif

endmodule
